/* design/tf2x32_pkg.sv */
// ----------------------------------------------------------------------------
// Threefry-2x32 package
// Shared types, round constants and the round function of the block.
// ----------------------------------------------------------------------------
package tf2x32_pkg;

    localparam int unsigned NUM_ROUNDS = 20;
    localparam int unsigned NUM_INJECT = NUM_ROUNDS / 4;
    localparam int unsigned RND_W      = $clog2(NUM_ROUNDS);

    localparam logic [31:0] PARITY_CONST = 32'h1BD1_1BDA;

    localparam logic [4:0] ROT_DIST [8] = '{5'd13, 5'd15, 5'd26, 5'd6,
                                            5'd17, 5'd29, 5'd16, 5'd24};

    // Key schedule word added to each lane at injection s (s = 1 to 5).
    localparam logic [1:0] INJ_A_SEL [NUM_INJECT] = '{2'd1, 2'd2, 2'd0, 2'd1, 2'd2};
    localparam logic [1:0] INJ_B_SEL [NUM_INJECT] = '{2'd2, 2'd0, 2'd1, 2'd2, 2'd0};

    typedef struct packed {
        logic [31:0] key_word_a;
        logic [31:0] key_word_b;
        logic [31:0] count_word_a;
        logic [31:0] count_word_b;
        logic        batch_end;
    } t_in_item;

    typedef struct packed {
        logic [31:0] random_word_a;
        logic [31:0] random_word_b;
        logic        batch_end_out;
    } t_out_item;

    // Working state that flows down the pipeline with the extended key.
    typedef struct packed {
        logic [31:0]      a;
        logic [31:0]      b;
        logic [2:0][31:0] ks;
        logic             batch_end;
    } t_state;

    function automatic logic [31:0] rotl32(logic [31:0] v, logic [4:0] d);
        logic [63:0] dbl;
        logic [63:0] sh;
        dbl = {v, v};
        sh  = dbl << d;
        return sh[63:32];
    endfunction

    // One add-rotate-xor round; every fourth round also injects the key schedule.
    function automatic t_state tf_round(t_state st, logic [RND_W-1:0] rnd);
        t_state      res;
        logic [31:0] rb;
        logic [2:0]  inj;
        res   = st;
        res.a = st.a + st.b;
        rb    = rotl32(st.b, ROT_DIST[rnd[2:0]]);
        res.b = rb ^ res.a;
        if (rnd[1:0] == 2'd3) begin
            inj   = 3'(rnd >> 2);
            res.a = res.a + st.ks[INJ_A_SEL[inj]];
            res.b = res.b + st.ks[INJ_B_SEL[inj]] + 32'(inj) + 32'd1;
        end
        return res;
    endfunction

endpackage

/* design/tf_in_if.sv */
// ----------------------------------------------------------------------------
// Threefry input channel
// Valid/ready channel carrying one key and counter per transaction.
// ----------------------------------------------------------------------------
interface tf_in_if import tf2x32_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* design/tf_out_if.sv */
// ----------------------------------------------------------------------------
// Threefry output channel
// Valid/ready channel carrying one random block per transaction.
// ----------------------------------------------------------------------------
interface tf_out_if import tf2x32_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* design/tf2x32_key_inject.sv */
// ----------------------------------------------------------------------------
// Threefry key extension stage
// Builds the parity key word and applies the initial key injection.
// ----------------------------------------------------------------------------
module tf2x32_key_inject import tf2x32_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_item i_item,
    output logic     o_valid,
    input  logic     i_ready,
    output t_state   o_state
);

    logic   r_valid;
    t_state r_state;
    t_state n_state;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        n_state.ks[0]     = i_item.key_word_a;
        n_state.ks[1]     = i_item.key_word_b;
        n_state.ks[2]     = PARITY_CONST ^ i_item.key_word_a ^ i_item.key_word_b;
        n_state.a         = i_item.count_word_a + i_item.key_word_a;
        n_state.b         = i_item.count_word_b + i_item.key_word_b;
        n_state.batch_end = i_item.batch_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_state <= n_state;
        end
    end

    assign o_valid = r_valid;
    assign o_state = r_state;

endmodule

/* design/tf2x32_round_pipe.sv */
// ----------------------------------------------------------------------------
// Threefry round pipeline
// One register stage per round with per-stage valid and bubble collapsing.
// ----------------------------------------------------------------------------
module tf2x32_round_pipe import tf2x32_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_state i_state,
    output logic   o_valid,
    input  logic   i_ready,
    output t_state o_state
);

    logic   r_valid  [NUM_ROUNDS];
    t_state r_state  [NUM_ROUNDS];
    logic   stg_in_v [NUM_ROUNDS];
    t_state stg_in   [NUM_ROUNDS];
    logic   stg_rdy  [NUM_ROUNDS];

    genvar k;
    generate
        for (k = 0; k < NUM_ROUNDS; k++) begin : g_stage
            if (k == 0) begin : g_first
                assign stg_in_v[k] = i_valid;
                assign stg_in[k]   = i_state;
            end else begin : g_next
                assign stg_in_v[k] = r_valid[k-1];
                assign stg_in[k]   = r_state[k-1];
            end

            if (k == NUM_ROUNDS - 1) begin : g_last_rdy
                assign stg_rdy[k] = !r_valid[k] || i_ready;
            end else begin : g_mid_rdy
                assign stg_rdy[k] = !r_valid[k] || stg_rdy[k+1];
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_valid[k] <= 1'b0;
                end else if (stg_rdy[k]) begin
                    r_valid[k] <= stg_in_v[k];
                end
            end

            always_ff @(posedge i_clk) begin
                if (stg_rdy[k] && stg_in_v[k]) begin
                    r_state[k] <= tf_round(stg_in[k], RND_W'(k));
                end
            end
        end
    endgenerate

    assign o_ready = stg_rdy[0];
    assign o_valid = r_valid[NUM_ROUNDS-1];
    assign o_state = r_state[NUM_ROUNDS-1];

endmodule

/* design/threefry_2x32_block_unit.sv */
// ----------------------------------------------------------------------------
// Threefry-2x32 block unit
// Twenty-round Threefry-2x32 counter-based random generator, fully pipelined.
// ----------------------------------------------------------------------------
// Usage: each transaction on i_in carries a 64-bit key (two words) and a
// 64-bit counter (two words) plus a batch-end flag. Each one yields exactly
// one transaction on o_out with the two random words and the copied flag.
// A result passes through one stage for the key extension and first
// injection, then one stage per round, with the key injections folded
// into every fourth round stage. Throughput is one transaction per cycle
// while o_out.ready stays high, set by the single-round stage depth.
// Each stage has its own valid bit and takes new data whenever it is empty
// or its successor moves, so bubbles close up under backpressure. When the
// receiver holds o_out.ready low, finished results wait in the last stage
// while earlier stages keep filling; i_in.ready drops only when every stage
// is occupied. Nothing is lost or repeated across a stall.
// Reset clears all valid bits; the data registers carry no reset.
// ----------------------------------------------------------------------------
module threefry_2x32_block_unit import tf2x32_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    tf_in_if.sink    i_in,
    tf_out_if.source o_out
);

    // Key extension stage to round pipeline handshake.
    logic   kx_valid;
    logic   kx_ready;
    t_state kx_state;

    // Round pipeline result.
    logic   rp_valid;
    t_state rp_state;

    tf2x32_key_inject u_key_inject (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_item  (i_in.data),
        .o_valid (kx_valid),
        .i_ready (kx_ready),
        .o_state (kx_state)
    );

    tf2x32_round_pipe u_round_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (kx_valid),
        .o_ready (kx_ready),
        .i_state (kx_state),
        .o_valid (rp_valid),
        .i_ready (o_out.ready),
        .o_state (rp_state)
    );

    // The last round stage already holds the final injection, so the two lanes
    // are the random words directly.
    assign o_out.valid              = rp_valid;
    assign o_out.data.random_word_a = rp_state.a;
    assign o_out.data.random_word_b = rp_state.b;
    assign o_out.data.batch_end_out = rp_state.batch_end;

endmodule

/* bench/tb_threefry_2x32_block_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Threefry-2x32 block unit testbench
// Sends key/counter transactions into the pipelined twenty-round block under
// bursty input traffic and a patterned, sometimes long-stalled output. Every
// result is compared with an independent computation of the same block.
// ----------------------------------------------------------------------------
module tb_threefry_2x32_block_unit import tf2x32_pkg::*; ();

    // The key schedule's third word is the xor of both key words and this
    // parity constant.
    localparam logic [31:0] KEY_PARITY = 32'h1BD1_1BDA;

    // Rotation distances. Odd key groups use the first four entries and even
    // groups use the last four.
    localparam int unsigned SPIN_DIST [8] = '{13, 15, 26, 6, 17, 29, 16, 24};

    // The pipeline is 21 stages deep; the drain wait is sized from that depth.
    localparam int unsigned PIPE_DEPTH   = 21;
    localparam int unsigned DRAIN_CYCLES = 2 * PIPE_DEPTH;
    localparam int unsigned RANDOM_ITEMS = 1030;

    // The output hold-off is much longer than the pipeline, so the block
    // fills completely and must drop its input ready.
    localparam int unsigned HOLD_CYCLES  = 96;
    localparam int unsigned HOLD_SPACING = 350;

    // The slowest correct gap between transactions is the output hold-off plus
    // a full pipeline refill. The watchdog allows many times that.
    localparam int unsigned IDLE_LIMIT = 1000;

    // ------------------------------------------------------------------------
    // Scoreboard: computes the expected block for every accepted request and
    // checks results in order.
    // ------------------------------------------------------------------------
    class block_checker;
        t_out_item   pending_blocks[$];
        int unsigned mismatches;

        function new();
            mismatches = 0;
        endfunction

        function logic [31:0] spin_left(logic [31:0] v, int unsigned d);
            // Every distance in the table is nonzero, so the right shift
            // never reaches 32.
            return (v << d) | (v >> (32 - d));
        endfunction

        function t_out_item threefry_block(t_in_item req);
            logic [31:0] sched [3];
            logic [31:0] x;
            logic [31:0] y;
            t_out_item   blk;
            sched[0] = req.key_word_a;
            sched[1] = req.key_word_b;
            sched[2] = KEY_PARITY ^ req.key_word_a ^ req.key_word_b;
            x = req.count_word_a + sched[0];
            y = req.count_word_b + sched[1];
            for (int unsigned grp = 1; grp <= 5; grp++) begin
                for (int unsigned r = 0; r < 4; r++) begin
                    x = x + y;
                    y = spin_left(y, SPIN_DIST[((grp - 1) % 2) * 4 + r]) ^ x;
                end
                // Key injection with the injection count added to lane b.
                x = x + sched[grp % 3];
                y = y + sched[(grp + 1) % 3] + 32'(grp);
            end
            blk.random_word_a = x;
            blk.random_word_b = y;
            blk.batch_end_out = req.batch_end;
            return blk;
        endfunction

        function void note_request(t_in_item req);
            pending_blocks.push_back(threefry_block(req));
        endfunction

        function void check_block(t_out_item got);
            t_out_item want;
            if (pending_blocks.size() == 0) begin
                $error("result with no request outstanding: a=%h b=%h end=%b",
                       got.random_word_a, got.random_word_b, got.batch_end_out);
                mismatches++;
                return;
            end
            want = pending_blocks.pop_front();
            if (got.random_word_a !== want.random_word_a) begin
                $error("random_word_a: expected %h, actual %h",
                       want.random_word_a, got.random_word_a);
                mismatches++;
            end
            if (got.random_word_b !== want.random_word_b) begin
                $error("random_word_b: expected %h, actual %h",
                       want.random_word_b, got.random_word_b);
                mismatches++;
            end
            if (got.batch_end_out !== want.batch_end_out) begin
                $error("batch_end_out: expected %b, actual %b",
                       want.batch_end_out, got.batch_end_out);
                mismatches++;
            end
        endfunction

        function int unsigned outstanding();
            return pending_blocks.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels and the block itself.
    // ------------------------------------------------------------------------
    logic i_clk;
    logic i_rst_n;

    tf_in_if  in_ch ();
    tf_out_if out_ch ();

    threefry_2x32_block_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    block_checker block_sb = new();

    // Run statistics, updated by the monitor at the rising edge.
    int unsigned n_requests     = 0;
    int unsigned n_results      = 0;
    int unsigned n_batch_ends   = 0;
    int unsigned n_input_stalls = 0;
    int unsigned idle_cycles    = 0;

    // Output hold-off in progress, in cycles left. The sender reads this to
    // keep offering transactions without gaps while the output is blocked.
    int unsigned hold_left  = 0;
    int unsigned holds_done = 0;

    // ------------------------------------------------------------------------
    // Monitor and watchdog. Both channels are sampled at the rising edge, so
    // the values seen are those set up at the preceding falling edge. The
    // watchdog counts cycles in which neither channel moves a transaction.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                block_sb.note_request(in_ch.data);
                n_requests++;
            end
            if (in_ch.valid && !in_ch.ready) begin
                n_input_stalls++;
            end
            if (out_ch.valid && out_ch.ready) begin
                block_sb.check_block(out_ch.data);
                n_results++;
                if (out_ch.data.batch_end_out) begin
                    n_batch_ends++;
                end
            end
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("no transaction for %0d cycles, %0d results outstanding",
                         IDLE_LIMIT, block_sb.outstanding());
                $display("threefry_2x32_block_unit test failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver. It changes its ready policy after each random-length stretch:
    // always ready, mostly ready, mostly stalled, or a fixed rhythm ready three
    // fifths of the time. Twice during the run it holds ready low for a long
    // stretch so that the pipeline fills and the input side sees backpressure.
    // ------------------------------------------------------------------------
    initial begin
        int unsigned stretch_left;
        int unsigned mode;
        int unsigned phase;
        logic        rdy;
        stretch_left = 0;
        mode         = 0;
        phase        = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left == 0 && holds_done < 2 &&
                n_requests >= (holds_done + 1) * HOLD_SPACING) begin
                hold_left = HOLD_CYCLES;
                holds_done++;
            end
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else begin
                if (stretch_left == 0) begin
                    mode         = $urandom_range(0, 3);
                    stretch_left = $urandom_range(16, 96);
                end
                stretch_left--;
                phase++;
                case (mode)
                    0: begin
                        rdy = 1'b1;
                    end
                    1: begin
                        rdy = ($urandom_range(0, 3) != 0);
                    end
                    2: begin
                        rdy = ($urandom_range(0, 3) == 0);
                    end
                    default: begin
                        rdy = ((phase % 5) < 3);
                    end
                endcase
            end
            out_ch.ready <= rdy;
        end
    end

    // ------------------------------------------------------------------------
    // Sender. Transactions go out in bursts of random length separated by
    // random gaps; some bursts are long enough to give unbroken stretches.
    // Valid is only lowered when a gap actually follows, so it never sees a
    // low and a high assignment in the same time step.
    // ------------------------------------------------------------------------
    int unsigned burst_left = 0;

    // Call at a falling edge; returns at the falling edge after acceptance.
    task automatic push_request(input t_in_item req);
        int unsigned gap;
        gap = 0;
        if (burst_left == 0) begin
            if (hold_left == 0 && $urandom_range(0, 3) != 0) begin
                gap = $urandom_range(1, 12);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200)
                                                      : $urandom_range(1, 40);
        end
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        burst_left--;
        in_ch.valid <= 1'b1;
        in_ch.data  <= req;
        do begin
            @(posedge i_clk);
        end while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    function automatic t_in_item make_request(logic [31:0] ka, logic [31:0] kb,
                                              logic [31:0] ca, logic [31:0] cb,
                                              logic be);
        t_in_item req;
        req.key_word_a   = ka;
        req.key_word_b   = kb;
        req.count_word_a = ca;
        req.count_word_b = cb;
        req.batch_end    = be;
        return req;
    endfunction

    // Words that sit at the corners of 32-bit arithmetic: zero, all ones,
    // a single bit, a single cleared bit, or the sign bit alone.
    function automatic logic [31:0] corner_word();
        logic [31:0] one_hot;
        one_hot = 32'd1 << $urandom_range(0, 31);
        case ($urandom_range(0, 4))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return one_hot;
            3:       return ~one_hot;
            default: return 32'h8000_0000;
        endcase
    endfunction

    // Counter-mode stream state: a fixed key with a 64-bit counter that steps
    // by one, the way the block is normally fed. The last item of a stream
    // carries the batch end flag.
    logic [31:0] stream_key_a;
    logic [31:0] stream_key_b;
    logic [63:0] stream_count;
    int unsigned stream_left = 0;

    function automatic t_in_item next_random_request();
        int unsigned roll;
        t_in_item    req;
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            if (stream_left == 0) begin
                stream_key_a = $urandom;
                stream_key_b = $urandom;
                // Some streams start just below a word boundary so the
                // increment can carry into the upper counter word.
                stream_count = {32'($urandom), 32'($urandom)};
                if ($urandom_range(0, 3) == 0) begin
                    stream_count[31:0] = 32'hFFFF_FFFF - $urandom_range(0, 8);
                end
                stream_left = $urandom_range(4, 64);
            end
            stream_left--;
            req = make_request(stream_key_a, stream_key_b, stream_count[31:0],
                               stream_count[63:32], stream_left == 0);
            stream_count = stream_count + 64'd1;
        end else if (roll < 85) begin
            req = make_request($urandom, $urandom, $urandom, $urandom,
                               1'($urandom_range(0, 1)));
        end else begin
            req = make_request(corner_word(), corner_word(), corner_word(),
                               corner_word(), 1'($urandom_range(0, 1)));
        end
        return req;
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence: reset, directed transactions, random traffic, drain and
    // verdict.
    // ------------------------------------------------------------------------
    initial begin
        in_ch.valid <= 1'b0;
        in_ch.data  <= '0;
        i_rst_n     <= 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // All-zero and all-one words, with the batch flag both ways.
        push_request(make_request(32'h0, 32'h0, 32'h0, 32'h0, 1'b0));
        push_request(make_request(32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
        push_request(make_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b0));
        push_request(make_request(32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
        // A published test vector built from the digits of pi.
        push_request(make_request(32'h1319_8A2E, 32'h0370_7344,
                                  32'h243F_6A88, 32'h85A3_08D3, 1'b0));
        // Key words that cancel the parity constant, so the third schedule
        // word is zero, and the same with the roles of the key words swapped.
        push_request(make_request(KEY_PARITY, 32'h0, 32'h1234_5678, 32'h9ABC_DEF0, 1'b0));
        push_request(make_request(32'h0, KEY_PARITY, 32'h0, 32'h1, 1'b1));
        // Carries out of both lanes in the very first key addition.
        push_request(make_request(32'h1, 32'h1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0));
        // Sign bits only, and alternating bit patterns.
        push_request(make_request(32'h8000_0000, 32'h8000_0000,
                                  32'h8000_0000, 32'h8000_0000, 1'b1));
        push_request(make_request(32'h5555_5555, 32'hAAAA_AAAA,
                                  32'hAAAA_AAAA, 32'h5555_5555, 1'b0));
        push_request(make_request(32'hAAAA_AAAA, 32'h5555_5555,
                                  32'h5555_5555, 32'hAAAA_AAAA, 1'b1));
        // Lowest counter bits and a repeated identical transaction.
        push_request(make_request(32'hDEAD_BEEF, 32'h0BAD_F00D, 32'h1, 32'h0, 1'b0));
        push_request(make_request(32'hDEAD_BEEF, 32'h0BAD_F00D, 32'h1, 32'h0, 1'b0));
        push_request(make_request(32'hDEAD_BEEF, 32'h0BAD_F00D, 32'h0, 32'h1, 1'b1));

        for (int unsigned k = 0; k < RANDOM_ITEMS; k++) begin
            push_request(next_random_request());
        end
        in_ch.valid <= 1'b0;

        while (block_sb.outstanding() != 0) begin
            @(posedge i_clk);
        end
        // The extra wait lets any surplus result show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d key/counter transactions and checked %0d blocks (%0d batch ends).",
                 n_requests, n_results, n_batch_ends);
        $display("Output hold-offs: %0d, input stalled for %0d cycles in total.",
                 holds_done, n_input_stalls);
        if (block_sb.mismatches == 0) begin
            $display("threefry_2x32_block_unit test passed");
        end else begin
            $display("threefry_2x32_block_unit test failed");
        end
        $finish;
    end

endmodule
